// ===== rtl/letterbox_viewport_mapper_assert.svh =====
// Assertion macros for the letterbox viewport mapper.
// Used by the modules under rtl that assert.
`ifndef LETTERBOX_VIEWPORT_MAPPER_ASSERT_SVH
`define LETTERBOX_VIEWPORT_MAPPER_ASSERT_SVH

// Implication checked at each clock edge, held off during reset
`define LVM_ASSERT_IMP(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Implication checked in the next cycle
`define LVM_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/lvm_pkg.sv =====
// Package for the letterbox viewport mapper: size width, opcodes, register indexes, states.
// No dependencies.
`timescale 1ns / 1ps
package lvm_pkg;
    // Width of the window and canvas size registers
    localparam int SIZE_BITS = 16;

    localparam logic [1:0] OP_PT_WIN   = 2'd0;
    localparam logic [1:0] OP_RECT_WIN = 2'd1;
    localparam logic [1:0] OP_PT_CAN   = 2'd2;
    localparam logic [1:0] OP_LEN_WIN  = 2'd3;

    localparam logic [2:0] REG_WW  = 3'd0;
    localparam logic [2:0] REG_WH  = 3'd1;
    localparam logic [2:0] REG_CW  = 3'd2;
    localparam logic [2:0] REG_CH  = 3'd3;
    localparam logic [2:0] REG_FIT = 3'd4;

    // Divider request: dividend, divisor
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CMP, ST_GCD, ST_GCD_W, ST_RN, ST_RN_W, ST_RD, ST_RD_W,
        ST_FIT, ST_FIT_W, ST_UW, ST_UW_W, ST_UH, ST_UH_W,
        ST_J0, ST_J0_W, ST_J1, ST_J1_W, ST_J2, ST_J2_W, ST_J3, ST_J3_W, ST_OUT
    } state_t;
endpackage

// ===== rtl/lvm_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on lvm_pkg.
`timescale 1ns / 1ps
`include "letterbox_viewport_mapper_assert.svh"
module lvm_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  lvm_pkg::div_req_t req,
    output lvm_pkg::div_rsp_t rsp
);
    import lvm_pkg::*;

    logic [63:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // One shift and subtract per cycle
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quot_reg[63]} - {1'b0, dvs_reg};
        if (req.start) begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = (req.divisor == '0) ? 32'd1 : req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial;
            end else begin
                rem_next = {rem_reg[31:0], quot_reg[63]};
            end
            quot_next = {quot_reg[62:0], ~trial[32]};
            cnt_next  = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg[31:0];

    `LVM_ASSERT_NEXT(a_done_ends_busy, aclk, aresetn, done_next, !busy_reg, "done while busy")
    `LVM_ASSERT_IMP(a_cnt_busy, aclk, aresetn, busy_reg, cnt_reg != 7'd0, "busy with zero count")
    `LVM_ASSERT_IMP(a_rem_small, aclk, aresetn, done_reg, rem_reg[31:0] < dvs_reg, "remainder too big")
endmodule

// ===== rtl/letterbox_viewport_mapper.sv =====
// Letterbox viewport mapper: one item at a time through one shared 64/32 divider.
// Each division step loads the value, multiplies it, launches the division and waits for the
// quotient; a length runs step J0, a point J0 and J1, a rect J0 to J3, then m_tvalid rises.
// s_tready stays low while busy and while a result waits. After a configuration write the
// next item first re-derives scale and offsets by gcd, reduce, optional integer fit and offset
// divisions, or scale 1/1, offs 0 if a size is zero. aresetn sync low: regs 0, scale 1/1, offs 0.
`timescale 1ns / 1ps
`include "letterbox_viewport_mapper_assert.svh"
module letterbox_viewport_mapper (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [lvm_pkg::SIZE_BITS-1:0] cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // opcode[1:0], pos_x[33:2], pos_y[65:34], rect_width[97:66],
    // rect_height[129:98], scale_value[161:130], zero fill to 168
    input  logic [167:0]                 s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_x[31:0], out_y[63:32], out_width[95:64], out_height[127:96],
    // out_scale[159:128]
    output logic [159:0]                 m_tdata
);
    import lvm_pkg::*;

    logic [SIZE_BITS-1:0] ww_reg, wh_reg, cw_reg, ch_reg;
    logic fit_reg, dv_reg, dv_next;
    logic [31:0] num_reg, num_next, den_reg, den_next;
    logic [31:0] gb_reg, gb_next;
    logic [31:0] offx_reg, offx_next, offy_reg, offy_next;
    logic [1:0]  op_reg;
    logic [31:0] px_reg, py_reg, rw_reg, rh_reg, sv_reg;
    logic [31:0] val_reg, val_next;
    logic        neg_reg, neg_next;
    logic [31:0] j0_reg, j0_next, j1_reg, j1_next, j2_reg, j2_next;
    logic [159:0] res_reg, res_next;
    logic        mv_reg, mv_next;
    state_t      st_reg, st_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] mulp;
    logic [31:0] mula, mulb, mag, q32, fs;
    div_req_t    dreq;
    div_rsp_t    drsp;

    lvm_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign cfg_ready = (st_reg == ST_IDLE);
    assign s_tready  = (st_reg == ST_IDLE) && !mv_reg;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = res_reg;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ww_reg <= '0; wh_reg <= '0; cw_reg <= '0; ch_reg <= '0; fit_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WW:  ww_reg  <= cfg_data;
                REG_WH:  wh_reg  <= cfg_data;
                REG_CW:  cw_reg  <= cfg_data;
                REG_CH:  ch_reg  <= cfg_data;
                REG_FIT: fit_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Magnitude of the value to scale, and the one shared multiplier
    assign mag  = neg_reg ? (32'd0 - val_reg) : val_reg;
    assign mulp = {32'd0, mula} * {32'd0, mulb};
    // Floor of signed product over divisor from quotient and remainder
    assign q32  = drsp.quot[31:0] + {31'd0, neg_reg && (drsp.rem != 32'd0)};
    assign fs   = neg_reg ? (32'd0 - q32) : drsp.quot[31:0];

    // Sequencer
    always_comb begin
        st_next = st_reg; dv_next = dv_reg;
        num_next = num_reg; den_next = den_reg; gb_next = gb_reg;
        offx_next = offx_reg; offy_next = offy_reg;
        val_next = val_reg; neg_next = neg_reg;
        j0_next = j0_reg; j1_next = j1_reg; j2_next = j2_reg;
        res_next = res_reg; mv_next = mv_reg;
        prod_next = prod_reg;
        mula = mag; mulb = num_reg;
        dreq.start = 1'b0; dreq.dividend = prod_reg; dreq.divisor = den_reg;
        if (mv_reg && m_tready) mv_next = 1'b0;
        case (st_reg)
            ST_IDLE: begin
                if (cfg_valid) dv_next = 1'b0;
                if (s_tvalid && s_tready) begin
                    st_next = (dv_reg && !cfg_valid) ? ST_J0 : ST_CMP;
                end
            end
            ST_CMP: begin
                num_next = 32'd1; den_next = 32'd1; offx_next = '0; offy_next = '0;
                dv_next = 1'b1;
                if (ww_reg == '0 || wh_reg == '0 || cw_reg == '0 || ch_reg == '0) begin
                    st_next = ST_J0;
                end else begin
                    mula = 32'(ww_reg); mulb = 32'(ch_reg);
                    prod_next = mulp;
                    st_next = ST_GCD;
                end
            end
            ST_GCD: begin
                // Compare ww*ch with wh*cw and seed the gcd
                mula = 32'(wh_reg); mulb = 32'(cw_reg);
                if (prod_reg < mulp) begin
                    num_next = 32'(ww_reg); den_next = 32'(cw_reg);
                    gb_next = 32'(cw_reg);
                end else begin
                    num_next = 32'(wh_reg); den_next = 32'(ch_reg);
                    gb_next = 32'(ch_reg);
                end
                st_next = ST_GCD_W;
                dreq.start = 1'b1;
                dreq.dividend = (prod_reg < mulp) ? 64'(ww_reg) : 64'(wh_reg);
                dreq.divisor  = (prod_reg < mulp) ? 32'(cw_reg) : 32'(ch_reg);
            end
            ST_GCD_W: begin
                if (drsp.done) begin
                    if (drsp.rem == '0) begin
                        st_next = ST_RN;
                    end else begin
                        gb_next = drsp.rem;
                        dreq.start = 1'b1;
                        dreq.dividend = 64'(gb_reg); dreq.divisor = drsp.rem;
                    end
                end
            end
            ST_RN: begin
                dreq.start = 1'b1; dreq.dividend = 64'(num_reg); dreq.divisor = gb_reg;
                st_next = ST_RN_W;
            end
            ST_RN_W: if (drsp.done) begin
                num_next = drsp.quot[31:0]; st_next = ST_RD;
            end
            ST_RD: begin
                dreq.start = 1'b1; dreq.dividend = 64'(den_reg); dreq.divisor = gb_reg;
                st_next = ST_RD_W;
            end
            ST_RD_W: if (drsp.done) begin
                den_next = drsp.quot[31:0]; st_next = fit_reg ? ST_FIT : ST_UW;
            end
            ST_FIT: begin
                dreq.start = 1'b1; dreq.dividend = 64'(num_reg); dreq.divisor = den_reg;
                st_next = ST_FIT_W;
            end
            ST_FIT_W: if (drsp.done) begin
                num_next = (drsp.quot[31:0] == '0) ? 32'd1 : drsp.quot[31:0];
                den_next = 32'd1; st_next = ST_UW;
            end
            ST_UW: begin
                mula = 32'(cw_reg); prod_next = mulp; neg_next = 1'b0;
                st_next = ST_UW_W;
            end
            ST_UW_W: begin
                if (!drsp.done && prod_reg[63:32] != 32'hFFFFFFFF) begin
                    dreq.start = 1'b1; prod_next = 64'hFFFFFFFF_FFFFFFFF;
                end else if (drsp.done) begin
                    offx_next = (32'(ww_reg) - drsp.quot[31:0]) >> 1;
                    st_next = ST_UH;
                end
            end
            ST_UH: begin
                mula = 32'(ch_reg); prod_next = mulp;
                st_next = ST_UH_W;
            end
            ST_UH_W: begin
                if (!drsp.done && prod_reg[63:32] != 32'hFFFFFFFF) begin
                    dreq.start = 1'b1; prod_next = 64'hFFFFFFFF_FFFFFFFF;
                end else if (drsp.done) begin
                    offy_next = (32'(wh_reg) - drsp.quot[31:0]) >> 1;
                    st_next = ST_J0;
                end
            end
            ST_J0: begin
                // Pick first value per opcode
                case (op_reg)
                    OP_PT_CAN:  val_next = px_reg - offx_reg;
                    OP_LEN_WIN: val_next = sv_reg;
                    default:    val_next = px_reg;
                endcase
                neg_next = (op_reg == OP_LEN_WIN) ? 1'b0 :
                           ((op_reg == OP_PT_CAN) ? (px_reg - offx_reg) : px_reg) >= 32'h80000000;
                st_next = ST_J0_W; prod_next = '1;
            end
            ST_J0_W, ST_J1_W, ST_J2_W, ST_J3_W: begin
                if (prod_reg == '1) begin
                    // Multiply then launch the division
                    mulb = (op_reg == OP_PT_CAN) ? den_reg : num_reg;
                    prod_next = mulp;
                end else if (!drsp.done && prod_reg[63] != 1'b1) begin
                    dreq.start = 1'b1;
                    dreq.divisor = (op_reg == OP_PT_CAN) ? num_reg : den_reg;
                    prod_next = {1'b1, prod_reg[62:0]};
                end else if (drsp.done) begin
                    case (st_reg)
                        ST_J0_W: begin
                            j0_next = fs;
                            if (op_reg == OP_LEN_WIN) begin
                                res_next = {((sv_reg != '0 && fs == '0) ? 32'd1 : fs),
                                            128'd0};
                                mv_next = 1'b1; st_next = ST_IDLE;
                            end else st_next = ST_J1;
                        end
                        ST_J1_W: begin
                            j1_next = fs;
                            if (op_reg == OP_RECT_WIN) st_next = ST_J2;
                            else begin
                                res_next = (op_reg == OP_PT_CAN) ?
                                    {96'd0, fs, j0_reg} :
                                    {96'd0, offy_reg + fs, offx_reg + j0_reg};
                                mv_next = 1'b1; st_next = ST_IDLE;
                            end
                        end
                        ST_J2_W: begin
                            j2_next = fs; st_next = ST_J3;
                        end
                        default: begin
                            res_next = {32'd0, fs - j1_reg, j2_reg - j0_reg,
                                        offy_reg + j1_reg, offx_reg + j0_reg};
                            mv_next = 1'b1; st_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_J1, ST_J2, ST_J3: begin
                case (st_reg)
                    ST_J1:   val_next = (op_reg == OP_PT_CAN) ? py_reg - offy_reg : py_reg;
                    ST_J2:   val_next = px_reg + rw_reg;
                    default: val_next = py_reg + rh_reg;
                endcase
                neg_next = val_next[31];
                prod_next = '1;
                case (st_reg)
                    ST_J1:   st_next = ST_J1_W;
                    ST_J2:   st_next = ST_J2_W;
                    default: st_next = ST_J3_W;
                endcase
            end
            default: st_next = ST_IDLE;
        endcase
        if (st_reg == ST_UW_W || st_reg == ST_UH_W) begin
            dreq.dividend = {1'b0, prod_reg[62:0]};
        end else if (st_reg == ST_J0_W || st_reg == ST_J1_W ||
                     st_reg == ST_J2_W || st_reg == ST_J3_W) begin
            dreq.dividend = {1'b0, prod_reg[62:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; mv_reg <= 1'b0; dv_reg <= 1'b0;
            num_reg <= 32'd1; den_reg <= 32'd1; offx_reg <= '0; offy_reg <= '0;
        end else begin
            st_reg <= st_next; mv_reg <= mv_next; dv_reg <= dv_next;
            num_reg <= num_next; den_reg <= den_next;
            offx_reg <= offx_next; offy_reg <= offy_next;
        end
        gb_reg <= gb_next;
        val_reg <= val_next; neg_reg <= neg_next;
        j0_reg <= j0_next; j1_reg <= j1_next; j2_reg <= j2_next;
        res_reg <= res_next; prod_reg <= prod_next;
        if (s_tvalid && s_tready) begin
            op_reg <= s_tdata[1:0];   px_reg <= s_tdata[33:2];  py_reg <= s_tdata[65:34];
            rw_reg <= s_tdata[97:66]; rh_reg <= s_tdata[129:98]; sv_reg <= s_tdata[161:130];
        end
    end

    `LVM_ASSERT_IMP(a_no_take_busy, aclk, aresetn, s_tready, st_reg == ST_IDLE && !mv_reg, "ready while busy")
    `LVM_ASSERT_NEXT(a_accept_leaves, aclk, aresetn, s_tvalid && s_tready, st_reg != ST_IDLE, "accept ignored")
    `LVM_ASSERT_IMP(a_den_nonzero, aclk, aresetn, st_reg == ST_J0, den_reg != '0 && num_reg != '0, "zero scale")
endmodule

// ===== tb/sv/lvm_scoreboard.sv =====
// Checker for the letterbox viewport mapper: watches the configuration, input and
// result channels, predicts each result and compares it field by field.
// Depends on lvm_pkg for opcodes and register indexes.
`timescale 1ns / 1ps
module lvm_scoreboard (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [167:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [159:0] m_tdata,
    output int           pending,
    output int           errors
);
    import lvm_pkg::*;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] len;
    } mapped_t;

    mapped_t mapped_q[$];

    logic [31:0] win_w, win_h, can_w, can_h;
    logic        int_fit;
    logic [31:0] scl_num, scl_den, off_x, off_y;
    logic        fit_fresh;

    // floor(v * mul / div) with v signed, low 32 bits kept
    function automatic logic [31:0] floor_mul_div(logic [31:0] v, logic [31:0] mul,
                                                  logic [31:0] div);
        logic [63:0] d, mag, prod, q;
        logic [31:0] negv;
        logic        neg;
        d    = (div == 0) ? 64'd1 : {32'd0, div};
        neg  = v[31];
        negv = ~v + 32'd1;
        mag  = neg ? {32'd0, negv} : {32'd0, v};
        if (neg && mag == 0) mag = 64'h8000_0000;
        prod = mag * {32'd0, mul};
        q    = prod / d;
        if (neg) begin
            if (prod % d != 0) q = q + 64'd1;
            q = 64'd0 - q;
        end
        return q[31:0];
    endfunction

    // Work out scale and centring offsets from the registers
    task automatic refit();
        logic [31:0] n, d, a, b, t, g, used_w, used_h;
        scl_num   = 1;
        scl_den   = 1;
        off_x     = 0;
        off_y     = 0;
        fit_fresh = 1'b1;
        if (win_w == 0 || win_h == 0 || can_w == 0 || can_h == 0) return;
        n = win_h;
        d = can_h;
        if ({32'd0, win_w} * {32'd0, can_h} < {32'd0, win_h} * {32'd0, can_w}) begin
            n = win_w;
            d = can_w;
        end
        a = n;
        b = d;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        g = (a == 0) ? 32'd1 : a;
        n = n / g;
        d = d / g;
        if (int_fit) begin
            n = n / d;
            if (n < 1) n = 1;
            d = 1;
        end
        scl_num = n;
        scl_den = d;
        used_w  = floor_mul_div(can_w, n, d);
        used_h  = floor_mul_div(can_h, n, d);
        off_x   = (win_w - used_w) / 2;
        off_y   = (win_h - used_h) / 2;
    endtask

    function automatic mapped_t map_item(logic [167:0] it);
        mapped_t     r;
        logic [1:0]  op;
        logic [31:0] px, py, rw, rh, sv, bx, by;
        logic [63:0] lp, dd;
        op = it[1:0];
        px = it[33:2];
        py = it[65:34];
        rw = it[97:66];
        rh = it[129:98];
        sv = it[161:130];
        r  = '{default: 32'd0};
        case (op)
            OP_PT_WIN, OP_RECT_WIN: begin
                r.x = off_x + floor_mul_div(px, scl_num, scl_den);
                r.y = off_y + floor_mul_div(py, scl_num, scl_den);
                if (op == OP_RECT_WIN) begin
                    bx  = off_x + floor_mul_div(px + rw, scl_num, scl_den);
                    by  = off_y + floor_mul_div(py + rh, scl_num, scl_den);
                    r.w = bx - r.x;
                    r.h = by - r.y;
                end
            end
            OP_PT_CAN: begin
                r.x = floor_mul_div(px - off_x, scl_den, scl_num);
                r.y = floor_mul_div(py - off_y, scl_den, scl_num);
            end
            default: begin
                if (sv != 0) begin
                    dd    = (scl_den == 0) ? 64'd1 : {32'd0, scl_den};
                    lp    = {32'd0, sv} * {32'd0, scl_num} / dd;
                    r.len = lp[31:0];
                    if (r.len == 0) r.len = 1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
            errors++;
        end
    endtask

    // Track registers, queue predictions, compare transfers on the result side
    always @(posedge aclk) begin
        mapped_t e;
        if (!aresetn) begin
            win_w     = 0;
            win_h     = 0;
            can_w     = 0;
            can_h     = 0;
            int_fit   = 0;
            scl_num   = 1;
            scl_den   = 1;
            off_x     = 0;
            off_y     = 0;
            fit_fresh = 0;
            mapped_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WW:  win_w   = {16'd0, cfg_data};
                    REG_WH:  win_h   = {16'd0, cfg_data};
                    REG_CW:  can_w   = {16'd0, cfg_data};
                    REG_CH:  can_h   = {16'd0, cfg_data};
                    REG_FIT: int_fit = cfg_data[0];
                    default: ;
                endcase
                if (cfg_index <= REG_FIT) fit_fresh = 1'b0;
            end
            if (s_tvalid && s_tready) begin
                if (!fit_fresh) refit();
                mapped_q.push_back(map_item(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (mapped_q.size() == 0) begin
                    $error("result transfer with no prediction waiting");
                    errors++;
                end else begin
                    e = mapped_q.pop_front();
                    check_field("out_x", e.x, m_tdata[31:0]);
                    check_field("out_y", e.y, m_tdata[63:32]);
                    check_field("out_width", e.w, m_tdata[95:64]);
                    check_field("out_height", e.h, m_tdata[127:96]);
                    check_field("out_scale", e.len, m_tdata[159:128]);
                end
            end
        end
        pending = mapped_q.size();
    end

    initial begin
        errors  = 0;
        pending = 0;
    end
endmodule

// ===== tb/sv/tb_letterbox_viewport_mapper.sv =====
// Testbench top for the letterbox viewport mapper: clock, reset, stimulus and verdict.
// Depends on lvm_pkg, letterbox_viewport_mapper and lvm_scoreboard.
`timescale 1ns / 1ps
module tb_letterbox_viewport_mapper;
    import lvm_pkg::*;

    localparam int N_PHASES  = 14;
    localparam int PER_PHASE = 125;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    int           pending;
    int           errors;
    logic         quiet;
    int           n_sent;

    letterbox_viewport_mapper dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    lvm_scoreboard chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .pending(pending), .errors(errors)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stall bursts, none once the run goes quiet
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (quiet) begin
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b0;
                repeat ($urandom_range(15, 1) - 1) @(negedge aclk);
                @(negedge aclk);
                m_tready = 1'b1;
                repeat ($urandom_range(30, 1) - 1) @(negedge aclk);
            end
        end
    end

    // Mix of full-range, small and extreme values
    function automatic logic [31:0] pick_word();
        case ($urandom_range(5, 0))
            0:       return $urandom_range(300, 0);
            1:       return 32'd0 - $urandom_range(300, 0);
            2:       return ($urandom_range(1, 0) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Drop the input and wait until every predicted result has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_view(logic [15:0] ww, logic [15:0] wh, logic [15:0] cw,
                            logic [15:0] ch, logic fit);
        drain();
        write_reg(REG_WW, ww);
        write_reg(REG_WH, wh);
        write_reg(REG_CW, cw);
        write_reg(REG_CH, ch);
        write_reg(REG_FIT, {15'd0, fit});
    endtask

    // Present one item, with an optional gap first, and hold it until transfer
    task automatic send_item(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                             logic [31:0] rw, logic [31:0] rh, logic [31:0] sv);
        @(negedge aclk);
        if (!quiet && $urandom_range(3, 0) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(15, 1)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, sv, rh, rw, py, px, op};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic send_random();
        send_item(2'($urandom_range(3, 0)), pick_word(), pick_word(), pick_word(),
                  pick_word(), pick_word());
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        quiet     = 1'b0;
        n_sent    = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Default viewport straight after reset
        send_item(OP_PT_WIN, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
        send_item(OP_LEN_WIN, 0, 0, 0, 0, 32'hffff_ffff);

        // Fractional scale of one third: extremes, every operation, length edge cases
        set_view(16'd100, 16'd60, 16'd300, 16'd70, 1'b0);
        send_item(OP_PT_WIN, 0, 0, 0, 0, 0);
        send_item(OP_PT_WIN, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
        send_item(OP_PT_WIN, 32'hffff_ffff, 32'h0000_0001, 0, 0, 0);
        send_item(OP_RECT_WIN, 10, 20, 30, 40, 0);
        send_item(OP_RECT_WIN, 32'h7fff_fff0, 32'hffff_fff0, 32'hffff_ffff, 32'hffff_ffff, 0);
        send_item(OP_RECT_WIN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_item(OP_PT_CAN, 0, 0, 0, 0, 0);
        send_item(OP_PT_CAN, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
        send_item(OP_PT_CAN, 32'hffff_fffb, 7, 0, 0, 0);
        send_item(OP_LEN_WIN, 0, 0, 0, 0, 0);
        send_item(OP_LEN_WIN, 0, 0, 0, 0, 1);
        send_item(OP_LEN_WIN, 0, 0, 0, 0, 3);
        send_item(OP_LEN_WIN, 0, 0, 0, 0, 32'hffff_ffff);

        // Tiny scale: lengths round to zero and become one
        set_view(16'd1, 16'd1, 16'hffff, 16'hffff, 1'b0);
        send_item(OP_LEN_WIN, 0, 0, 0, 0, 1);
        send_item(OP_PT_CAN, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);

        // Integer floor below one: overflowing canvas wraps the offsets
        set_view(16'd1, 16'd1, 16'hffff, 16'hffff, 1'b1);
        send_item(OP_PT_WIN, 5, 32'hffff_fffb, 0, 0, 0);
        send_item(OP_LEN_WIN, 0, 0, 0, 0, 2);

        // Largest scale: wrap on mapped coordinates and lengths
        set_view(16'hffff, 16'hffff, 16'd1, 16'd1, 1'b1);
        send_item(OP_PT_WIN, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
        send_item(OP_LEN_WIN, 0, 0, 0, 0, 32'hffff_ffff);

        // Random settings, extremes first
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       set_view(16'd0, 16'd480, 16'd320, 16'd200, 1'b0);
                1:       set_view(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
                2:       set_view(16'hffff, 16'hffff, 16'd1, 16'd1, 1'b1);
                3:       set_view(16'd1, 16'd1, 16'hffff, 16'hffff, 1'b0);
                4:       set_view(16'd1, 16'd1, 16'hffff, 16'hffff, 1'b1);
                5:       set_view(16'd640, 16'd480, 16'd320, 16'd200, 1'b1);
                6:       set_view(16'd1920, 16'd1080, 16'd0, 16'd0, 1'b1);
                default: set_view(16'($urandom), 16'($urandom_range(4000, 1)),
                                  16'($urandom_range(4000, 1)), 16'($urandom),
                                  1'($urandom_range(1, 0)));
            endcase
            if (p == N_PHASES - 1) quiet = 1'b1;
            for (int i = 0; i < PER_PHASE; i++) begin
                // Hold off mid-phase until every outstanding result is back
                if (p == 8 && i == PER_PHASE / 2) begin
                    @(negedge aclk);
                    s_tvalid = 1'b0;
                    while (pending != 0) @(negedge aclk);
                end
                send_random();
            end
        end

        drain();
        repeat (300) @(posedge aclk);
        $display("Sent %0d items over %0d viewport settings, all four operations,",
                 n_sent, N_PHASES + 5);
        $display("with stalls on both channels and a drained-pipeline pause.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lvm_pkg.sv
rtl/lvm_divider.sv
rtl/letterbox_viewport_mapper.sv
tb/sv/lvm_scoreboard.sv
tb/sv/tb_letterbox_viewport_mapper.sv
